// ===== src/srev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srev_pkg
// Shared constants, types and arithmetic helpers of the Schroeder reverb.
// ----------------------------------------------------------------------------
package srev_pkg;

    localparam int COMB_DEPTH  = 4096;
    localparam int AP_DEPTH    = 512;
    localparam int NUM_COMBS   = 4;
    localparam int NUM_AP      = 2;

    localparam int COMB_OFS_W  = $clog2(COMB_DEPTH);
    localparam int AP_OFS_W    = $clog2(AP_DEPTH);
    localparam int COMB_IDX_W  = $clog2(NUM_COMBS);
    localparam int AP_IDX_W    = $clog2(NUM_AP);
    localparam int COMB_AW     = COMB_IDX_W + COMB_OFS_W;
    localparam int AP_AW       = AP_IDX_W + AP_OFS_W;
    localparam int IDX_W       = (COMB_IDX_W > AP_IDX_W) ? COMB_IDX_W : AP_IDX_W;
    localparam int SEEN_W      = 13;
    localparam int VAL_W       = 20;
    localparam int SUM_W       = 23;

    // configuration register indexes
    localparam logic [2:0] REG_COMB0 = 3'd0;
    localparam logic [2:0] REG_COMB1 = 3'd1;
    localparam logic [2:0] REG_COMB2 = 3'd2;
    localparam logic [2:0] REG_COMB3 = 3'd3;
    localparam logic [2:0] REG_AP0   = 3'd4;
    localparam logic [2:0] REG_AP1   = 3'd5;
    localparam logic [2:0] REG_WET   = 3'd6;

    localparam logic [12:0] COMB_RST [NUM_COMBS] = '{13'd1425, 13'd864, 13'd2160, 13'd2880};
    localparam logic [9:0]  AP_RST   [NUM_AP]    = '{10'd240, 10'd81};
    localparam logic signed [17:0] COMB_GAIN [NUM_COMBS] =
        '{18'sd26378, 18'sd27099, 18'sd25657, 18'sd25035};
    localparam logic signed [17:0] AP_GAIN   = 18'sd22938;
    localparam logic [15:0] WET_RST   = 16'd32768;
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(COMB_DEPTH);

    // shared multiplier operand and product
    typedef logic signed [20:0] t_mul_a;
    typedef logic signed [17:0] t_mul_b;
    typedef logic signed [38:0] t_prod;

    typedef enum logic [3:0] {
        S_IDLE, S_CRD, S_CMUL, S_CWR, S_ARD, S_AMUL, S_AWR,
        S_MIX1, S_MIX2, S_MIX3, S_OUT
    } t_state;

    // round half up: floor((p + 2^14) / 2^15)
    function automatic logic signed [24:0] rnd_q15(input logic signed [39:0] p);
        logic signed [39:0] t;
        t = p + 40'sd16384;
        return 25'(t >>> 15);
    endfunction

    function automatic logic signed [VAL_W-1:0] sat20(input logic signed [SUM_W+1:0] v);
        if (v > 25'sd524287)       return 20'sd524287;
        else if (v < -25'sd524288) return -20'sd524288;
        else                       return v[VAL_W-1:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [24:0] v);
        if (v > 25'sd32767)       return 16'sd32767;
        else if (v < -25'sd32768) return -16'sd32768;
        else                      return v[15:0];
    endfunction

    // delay clamp to [1, depth]
    function automatic logic [SEEN_W-1:0] clamp_comb(input logic [12:0] d);
        if (d == 13'd0)                      return SEEN_W'(1);
        else if (d > 13'(COMB_DEPTH))        return SEEN_W'(COMB_DEPTH);
        else                                 return d;
    endfunction

    function automatic logic [SEEN_W-1:0] clamp_ap(input logic [9:0] d);
        if (d == 10'd0)                      return SEEN_W'(1);
        else if (d > 10'(AP_DEPTH))          return SEEN_W'(AP_DEPTH);
        else                                 return SEEN_W'(d);
    endfunction

endpackage

// ===== src/srev_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srev_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module srev_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/srev_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srev_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module srev_mul (
    input  logic            i_clk,
    input  srev_pkg::t_mul_a i_a,
    input  srev_pkg::t_mul_b i_b,
    output srev_pkg::t_prod  o_p
);
    import srev_pkg::*;

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ===== src/schroeder_reverb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// schroeder_reverb_top
// Four feedback combs, two all-pass sections and a dry/wet mix.
// ----------------------------------------------------------------------------
// One sample is taken per transaction and one mixed sample is returned. The
// block works on one sample at a time: each comb steps through S_CRD, S_CMUL
// and S_CWR, each all-pass section through S_ARD, S_AMUL and S_AWR, the mix
// through S_MIX1 to S_MIX3, and S_OUT rounds into the output register. The
// result is valid as the input reopens, an order set by the single shared
// multiplier and the registered RAM read port. A new sample may be accepted
// while the previous result still waits; processing then holds in S_OUT
// until that result is taken. Delay lines are RAMs; history reads as zero
// until enough samples were seen, so no clearing pass runs after reset.
// Configuration must be written while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module schroeder_reverb_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] sample_out
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import srev_pkg::*;

    t_state r_state, n_state;

    logic [12:0] r_comb_d [NUM_COMBS];
    logic [9:0]  r_ap_d   [NUM_AP];
    logic [15:0] r_wet;

    logic [COMB_OFS_W-1:0] r_wp;
    logic [AP_OFS_W-1:0]   r_ap_pos;
    logic [SEEN_W-1:0]     r_seen;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_rd_ok;
    logic signed [15:0]    r_dry;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_s;
    logic signed [39:0]    r_pmix;
    logic signed [15:0]    r_out;
    logic                  r_out_vld;

    // datapath signals
    logic [SEEN_W-1:0]     cd, ad;
    logic [COMB_OFS_W-1:0] c_ofs;
    logic [AP_OFS_W-1:0]   a_ofs;
    logic [COMB_AW-1:0]    c_raddr, c_waddr;
    logic [AP_AW-1:0]      a_raddr, a_waddr;
    logic [VAL_W-1:0]      c_rdata, ai_rdata, ao_rdata;
    logic                  c_we, a_we;
    t_mul_a                mul_a;
    t_mul_b                mul_b;
    t_prod                 prod;
    logic signed [24:0]    prnd;
    logic signed [VAL_W-1:0] y_comb, y_ap;
    logic signed [SUM_W-1:0] sum_nx;
    logic [16:0]           w_cl;
    logic signed [39:0]    mix_tot;
    logic                  last_comb, last_ap;

    // current delays and read addresses
    assign cd      = clamp_comb(r_comb_d[r_idx[COMB_IDX_W-1:0]]);
    assign ad      = clamp_ap(r_ap_d[r_idx[AP_IDX_W-1:0]]);
    assign c_ofs   = r_wp - cd[COMB_OFS_W-1:0];
    assign a_ofs   = r_ap_pos - ad[AP_OFS_W-1:0];
    assign c_raddr = {r_idx[COMB_IDX_W-1:0], c_ofs};
    assign c_waddr = {r_idx[COMB_IDX_W-1:0], r_wp};
    assign a_raddr = {r_idx[AP_IDX_W-1:0], a_ofs};
    assign a_waddr = {r_idx[AP_IDX_W-1:0], r_ap_pos};
    assign last_comb = (r_idx == IDX_W'(NUM_COMBS - 1));
    assign last_ap   = (r_idx == IDX_W'(NUM_AP - 1));

    assign prnd   = rnd_q15(40'(prod));
    assign y_comb = sat20(25'(r_dry) + prnd);
    assign y_ap   = sat20(25'(r_s) + prnd);
    assign sum_nx = r_sum + SUM_W'(y_comb);
    assign w_cl   = (r_wet > 16'd32768) ? 17'd32768 : 17'(r_wet);
    assign mix_tot = r_pmix + 40'(prod);

    assign c_we = (r_state == S_CWR);
    assign a_we = (r_state == S_AWR);

    srev_ram #(.DEPTH(NUM_COMBS * COMB_DEPTH), .WIDTH(VAL_W)) u_comb_ram (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(y_comb),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );
    srev_ram #(.DEPTH(NUM_AP * AP_DEPTH), .WIDTH(VAL_W)) u_apin_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(r_s),
        .i_raddr(a_raddr), .o_rdata(ai_rdata)
    );
    srev_ram #(.DEPTH(NUM_AP * AP_DEPTH), .WIDTH(VAL_W)) u_apout_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(y_ap),
        .i_raddr(a_raddr), .o_rdata(ao_rdata)
    );

    srev_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(prod));

    // multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_CMUL: begin
                mul_a = r_rd_ok ? t_mul_a'($signed(c_rdata)) : '0;
                mul_b = COMB_GAIN[r_idx[COMB_IDX_W-1:0]];
            end
            S_AMUL: begin
                mul_a = r_rd_ok ? (t_mul_a'($signed(ao_rdata)) - t_mul_a'($signed(ai_rdata)))
                                : '0;
                mul_b = AP_GAIN;
            end
            S_MIX1: begin
                mul_a = t_mul_a'(r_dry);
                mul_b = t_mul_b'(17'd32768 - w_cl);
            end
            S_MIX2: begin
                mul_a = t_mul_a'(r_s);
                mul_b = t_mul_b'(w_cl);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = S_CRD;
            S_CRD:  n_state = S_CMUL;
            S_CMUL: n_state = S_CWR;
            S_CWR:  n_state = last_comb ? S_ARD : S_CRD;
            S_ARD:  n_state = S_AMUL;
            S_AMUL: n_state = S_AWR;
            S_AWR:  n_state = last_ap ? S_MIX1 : S_ARD;
            S_MIX1: n_state = S_MIX2;
            S_MIX2: n_state = S_MIX3;
            S_MIX3: n_state = S_OUT;
            S_OUT:  if (!r_out_vld || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comb_d <= COMB_RST;
            r_ap_d   <= AP_RST;
            r_wet    <= WET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_COMB0: r_comb_d[0] <= i_cfg_data[12:0];
                REG_COMB1: r_comb_d[1] <= i_cfg_data[12:0];
                REG_COMB2: r_comb_d[2] <= i_cfg_data[12:0];
                REG_COMB3: r_comb_d[3] <= i_cfg_data[12:0];
                REG_AP0:   r_ap_d[0]   <= i_cfg_data[9:0];
                REG_AP1:   r_ap_d[1]   <= i_cfg_data[9:0];
                REG_WET:   r_wet       <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // control counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_ap_pos  <= '0;
            r_seen    <= '0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_out_vld || m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_CWR: r_idx <= last_comb ? '0 : r_idx + 1'b1;
                S_AWR: r_idx <= last_ap ? '0 : r_idx + 1'b1;
                S_OUT: if (!r_out_vld || m_axis_tready) begin
                    r_wp      <= r_wp + 1'b1;
                    r_ap_pos  <= r_ap_pos + 1'b1;
                    if (r_seen < SEEN_MAX) r_seen <= r_seen + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_dry <= $signed(s_axis_tdata);
                r_sum <= '0;
            end
            S_CRD:  r_rd_ok <= (r_seen >= cd);
            S_CWR: begin
                r_sum <= sum_nx;
                if (last_comb) r_s <= sat20(25'(sum_nx));
            end
            S_ARD:  r_rd_ok <= (r_seen >= ad);
            S_AWR:  r_s <= y_ap;
            S_MIX2: r_pmix <= 40'(prod);
            S_MIX3: r_pmix <= mix_tot;
            // load the output only once the previous result has left
            S_OUT:  if (!r_out_vld || m_axis_tready) r_out <= sat16(rnd_q15(r_pmix));
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;
endmodule
